// ===== design/apl_pkg.sv =====
`default_nettype none

package apl_pkg;

	// Defaults for the top-level parameters.
	localparam int POINTS_DEF      = 5;
	localparam int DEGREE_STEP_DEF = 45;
	localparam int SAMPLE_BITS_DEF = 12;

	// Fixed field widths.
	localparam int BP_W       = 12;
	localparam int AVG_W      = 12;
	localparam int ANG_OUT_W  = 16;
	localparam int SEG_W      = 3;
	localparam int SEG_OUT_W  = 2;
	localparam int LOG2_W     = 3;
	localparam int CNT_W      = 7;

	// Configuration port.
	localparam int BP_REGS    = 5;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_ADDR_W-1:0] CFG_AVG_LOG2 = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_BP_FIRST = 3'd1;

	localparam logic [LOG2_W-1:0] AVG_LOG2_RESET = 3'd5;

	typedef enum logic [1:0] {
		ST_INTERP   = 2'd0,
		ST_CLAMP_LO = 2'd1,
		ST_CLAMP_HI = 2'd2,
		ST_NONE     = 2'd3
	} apl_status_t;

	// One classified average, handed from the front end to the back end.
	typedef struct packed {
		logic [AVG_W-1:0] average;
		apl_status_t      status;
		logic [SEG_W-1:0] seg;
		logic [BP_W-1:0]  diff;
		logic [BP_W-1:0]  span;
	} apl_req_t;

	function automatic logic [BP_W-1:0] bp_reset(input int idx);
		logic [BP_W-1:0] val;
		case (idx)
			0:       val = 12'd4095;
			1:       val = 12'd3071;
			2:       val = 12'd2047;
			3:       val = 12'd1023;
			default: val = 12'd0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

// ===== design/apl_queue.sv =====
`default_nettype none

module apl_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/apl_front.sv =====
`default_nettype none

module apl_front #(
	parameter int POINTS      = apl_pkg::POINTS_DEF,
	parameter int SAMPLE_BITS = apl_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  wire logic [SAMPLE_BITS-1:0]                sample,
	output logic                                       full,
	input  wire logic [apl_pkg::LOG2_W-1:0]            avg_log2,
	input  wire logic [POINTS-1:0][apl_pkg::BP_W-1:0]  bp,
	output logic                                       q_push,
	output apl_pkg::apl_req_t                          q_req,
	input  wire logic                                  q_full
);

	localparam int SUM_W = SAMPLE_BITS + apl_pkg::CNT_W;
	localparam int CMP_W = (SAMPLE_BITS > apl_pkg::BP_W) ? SAMPLE_BITS : apl_pkg::BP_W;
	localparam int TGT_W = apl_pkg::CNT_W + 1;
	localparam logic [SUM_W-1:0] SMAX_WIDE = SUM_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [SUM_W-1:0]            sum_q;
	logic [apl_pkg::CNT_W-1:0]   cnt_q;
	logic                        valid_s1;
	logic [SUM_W-1:0]            sum_s1;
	logic [apl_pkg::LOG2_W-1:0]  log2_s1;

	logic                        accept;
	logic [apl_pkg::CNT_W-1:0]   cnt_n;
	logic [TGT_W-1:0]            target;
	logic                        done;
	logic [SUM_W-1:0]            sum_n;
	logic [SUM_W-1:0]            avg_sh;
	logic [SAMPLE_BITS-1:0]      avg_sat;
	logic [CMP_W-1:0]            avg_c;
	logic [apl_pkg::BP_W-1:0]    avg12;

	assign full   = valid_s1 && q_full;
	assign q_push = valid_s1 && !q_full;
	assign accept = push && !full;
	assign cnt_n  = cnt_q + apl_pkg::CNT_W'(1);
	assign target = TGT_W'(1) << avg_log2;
	// A block ends when the count reaches the block size or wraps past 127.
	assign done   = (cnt_n == '0) || ({1'b0, cnt_n} >= target);
	assign sum_n  = sum_q + SUM_W'(sample);

	assign avg_sh  = sum_s1 >> log2_s1;
	assign avg_sat = (avg_sh > SMAX_WIDE) ? '1 : avg_sh[SAMPLE_BITS-1:0];
	assign avg_c   = CMP_W'(avg_sat);
	assign avg12   = avg_c[apl_pkg::BP_W-1:0];

	always_comb begin
		logic found;
		found         = 1'b0;
		q_req         = '0;
		q_req.average = apl_pkg::AVG_W'(avg_sat);
		q_req.status  = apl_pkg::ST_NONE;
		if (avg_c >= CMP_W'(bp[0])) begin
			q_req.status = apl_pkg::ST_CLAMP_LO;
		end else if (avg_c <= CMP_W'(bp[POINTS-1])) begin
			q_req.status = apl_pkg::ST_CLAMP_HI;
			q_req.seg    = apl_pkg::SEG_W'(POINTS - 2);
		end else begin
			for (int i = 0; i < POINTS - 1; i++) begin
				if (!found && avg_c <= CMP_W'(bp[i]) && avg_c >= CMP_W'(bp[i+1])) begin
					found        = 1'b1;
					q_req.status = apl_pkg::ST_INTERP;
					q_req.seg    = apl_pkg::SEG_W'(i);
					q_req.diff   = bp[i] - avg12;
					q_req.span   = bp[i] - bp[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (done) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
				end
			end
			if (accept && done) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) begin
			sum_s1  <= sum_n;
			log2_s1 <= avg_log2;
		end
	end

endmodule

`default_nettype wire

// ===== design/apl_back.sv =====
`default_nettype none

module apl_back #(
	parameter int POINTS      = apl_pkg::POINTS_DEF,
	parameter int DEGREE_STEP = apl_pkg::DEGREE_STEP_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_empty,
	input  wire apl_pkg::apl_req_t                 q_rdata,
	output logic                                   q_pop,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [apl_pkg::AVG_W-1:0]              average,
	output logic [apl_pkg::ANG_OUT_W-1:0]          angle_q8,
	output logic [apl_pkg::SEG_OUT_W-1:0]          segment,
	output logic [1:0]                             status
);

	localparam int FRAC_MAX = DEGREE_STEP * 256;
	localparam int Q_W      = $clog2(FRAC_MAX + 1);
	localparam int STEP_W   = $clog2(DEGREE_STEP + 1);
	localparam int PROD_W   = apl_pkg::BP_W + STEP_W;
	localparam int NUM_W    = PROD_W + 8;
	localparam int ANG_W    = $clog2((POINTS - 1) * FRAC_MAX + 1);
	localparam int QC_W     = $clog2(Q_W + 1);
	localparam logic [ANG_W-1:0] ANG_FULL = ANG_W'((POINTS - 1) * FRAC_MAX);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic                      out_valid_q;
	apl_pkg::apl_req_t         req_q;
	logic [apl_pkg::BP_W-1:0]  rem_q;
	logic [Q_W-1:0]            low_q;
	logic [Q_W-1:0]            quot_q;
	logic [QC_W-1:0]           cnt_q;

	logic [PROD_W-1:0]         prod;
	logic [NUM_W-1:0]          num;
	logic [apl_pkg::BP_W:0]    trial;
	logic [apl_pkg::BP_W:0]    span_x;
	logic [apl_pkg::BP_W:0]    sub;
	logic                      ge;
	logic                      last;
	logic                      load;
	logic [ANG_W-1:0]          ang_interp;
	logic [ANG_W-1:0]          ang_sel;
	logic [apl_pkg::ANG_OUT_W-1:0] ang_out;

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign empty = !out_valid_q;
	assign load  = (state_q == S_DONE) && (!out_valid_q || pop);

	// Numerator (b[i] - avg) * step * 256; the quotient never exceeds step * 256.
	assign prod   = PROD_W'(req_q.diff) * PROD_W'(DEGREE_STEP);
	assign num    = {prod, 8'h00};
	assign trial  = {rem_q, low_q[Q_W-1]};
	assign span_x = {1'b0, req_q.span};
	assign ge     = (trial >= span_x);
	assign sub    = trial - span_x;
	assign last   = (cnt_q == QC_W'(Q_W - 1));

	assign ang_interp = ANG_W'(req_q.seg) * ANG_W'(FRAC_MAX) + ANG_W'(quot_q);

	always_comb begin
		case (req_q.status)
			apl_pkg::ST_INTERP:   ang_sel = ang_interp;
			apl_pkg::ST_CLAMP_HI: ang_sel = ANG_FULL;
			default:              ang_sel = '0;
		endcase
		ang_out = (ang_sel > ANG_W'(32'hFFFF)) ? '1 : apl_pkg::ANG_OUT_W'(ang_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			average     <= '0;
			angle_q8    <= '0;
			segment     <= '0;
			status      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_rdata.status == apl_pkg::ST_INTERP && q_rdata.span != '0) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
				average     <= req_q.average;
				angle_q8    <= ang_out;
				segment     <= req_q.seg[apl_pkg::SEG_OUT_W-1:0];
				status      <= req_q.status;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q  <= q_rdata;
			quot_q <= '0;
		end
		if (state_q == S_MUL) begin
			rem_q <= apl_pkg::BP_W'(num[NUM_W-1:Q_W]);
			low_q <= num[Q_W-1:0];
			cnt_q <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q  <= ge ? sub[apl_pkg::BP_W-1:0] : trial[apl_pkg::BP_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[Q_W-2:0], ge};
			cnt_q  <= cnt_q + QC_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/averaged_piecewise_linearizer.sv =====
// Averaging angle converter.
// Input channel: raw converter readings are offered on sample with push and
// are taken whenever full is low. The block sums 2^average_log2 readings and
// turns the truncated mean into an angle in Q8.8 by linear interpolation over
// the calibration breakpoints, one result request per completed block.
// Result channel: while empty is low the oldest result request sits on
// average, angle_q8, segment and status; pop takes it.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 = average_log2, 1..5 = breakpoints) at once; write only while idle.
// A completed block passes through the front-end stage, the request queue and
// the back-end states to the output register; nonzero-span interpolations run
// through the multiply state and the serial divider, whose quotient is 14 bits
// wide at a 45 degree step. The divider resolves one quotient bit per cycle and
// handles one request at a time, taking the next only after its result is loaded.
// Samples are taken every cycle except while a finished average waits in front
// of a full two-entry request queue between the accumulator and the divider.
// Reset clears the accumulator, the queue and the output register, and loads
// the default registers. When the receiver stalls, the result holds; the
// divider and then the queue fill, after which full rises.
`default_nettype none

module averaged_piecewise_linearizer #(
	parameter int POINTS      = apl_pkg::POINTS_DEF,
	parameter int DEGREE_STEP = apl_pkg::DEGREE_STEP_DEF,
	parameter int SAMPLE_BITS = apl_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	input  wire logic [SAMPLE_BITS-1:0]            sample,
	output logic                                   full,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [apl_pkg::AVG_W-1:0]              average,
	output logic [apl_pkg::ANG_OUT_W-1:0]          angle_q8,
	output logic [apl_pkg::SEG_OUT_W-1:0]          segment,
	output logic [1:0]                             status,
	input  wire logic                              cfg_wr_en,
	input  wire logic [apl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [apl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int REQ_W = $bits(apl_pkg::apl_req_t);

	logic [apl_pkg::LOG2_W-1:0]          avg_log2_q;
	logic [POINTS-1:0][apl_pkg::BP_W-1:0] bp;

	apl_pkg::apl_req_t  front_req;
	apl_pkg::apl_req_t  back_req;
	logic [REQ_W-1:0]   q_wdata;
	logic [REQ_W-1:0]   q_rdata;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;

	// The sample-count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_log2_q <= apl_pkg::AVG_LOG2_RESET;
		end else if (cfg_wr_en && cfg_addr == apl_pkg::CFG_AVG_LOG2) begin
			avg_log2_q <= cfg_wdata[apl_pkg::LOG2_W-1:0];
		end
	end

	// Breakpoint registers. Points beyond the register list have no storage
	// and read as zero.
	for (genvar i = 0; i < POINTS; i++) begin : gen_bp
		if (i < apl_pkg::BP_REGS) begin : g_reg
			logic [apl_pkg::BP_W-1:0] bp_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					bp_q <= apl_pkg::bp_reset(i);
				end else if (cfg_wr_en &&
				             cfg_addr == apl_pkg::CFG_ADDR_W'(apl_pkg::CFG_BP_FIRST + i)) begin
					bp_q <= cfg_wdata[apl_pkg::BP_W-1:0];
				end
			end
			assign bp[i] = bp_q;
		end else begin : g_zero
			assign bp[i] = '0;
		end
	end

	apl_front #(
		.POINTS      (POINTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.avg_log2 (avg_log2_q),
		.bp       (bp),
		.q_push   (q_push),
		.q_req    (front_req),
		.q_full   (q_full)
	);

	assign q_wdata  = front_req;
	assign back_req = apl_pkg::apl_req_t'(q_rdata);

	apl_queue #(
		.WIDTH (REQ_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	apl_back #(
		.POINTS      (POINTS),
		.DEGREE_STEP (DEGREE_STEP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (back_req),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.average  (average),
		.angle_q8 (angle_q8),
		.segment  (segment),
		.status   (status)
	);

endmodule

`default_nettype wire

// ===== design/apl_checker.sv =====
`default_nettype none

module apl_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              full,
	input wire logic                              empty,
	input wire logic                              pop,
	input wire logic [apl_pkg::AVG_W-1:0]         average,
	input wire logic [apl_pkg::ANG_OUT_W-1:0]     angle_q8,
	input wire logic [apl_pkg::SEG_OUT_W-1:0]     segment,
	input wire logic [1:0]                        status
);

	// Reset leaves no request in flight and the input open.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("request visible or input closed during reset");

	// A waiting result request holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(average) && $stable(angle_q8) &&
		                      $stable(segment) && $stable(status)))
		else $error("result request changed while stalled");

	// Clamping at the low end reports angle zero in the first segment.
	a_clamp_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == apl_pkg::ST_CLAMP_LO) |-> (angle_q8 == '0 && segment == '0))
		else $error("low-end clamp with nonzero angle or segment");

	// An unmatched table reports angle zero in the first segment.
	a_no_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == apl_pkg::ST_NONE) |-> (angle_q8 == '0 && segment == '0))
		else $error("unmatched result with nonzero angle or segment");

endmodule

bind averaged_piecewise_linearizer apl_checker u_apl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.average  (average),
	.angle_q8 (angle_q8),
	.segment  (segment),
	.status   (status)
);

`default_nettype wire

// ===== test/angle_result_checker.sv =====
module angle_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [11:0] sample,
	input  logic        full,
	input  logic        empty,
	input  logic        pop,
	input  logic [11:0] average,
	input  logic [15:0] angle_q8,
	input  logic [1:0]  segment,
	input  logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [11:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	localparam int PTS  = apl_pkg::POINTS_DEF;
	localparam int STEP = apl_pkg::DEGREE_STEP_DEF;
	localparam logic [1:0] SEG_LAST = 2'(PTS - 2);

	typedef struct packed {
		logic [11:0]          average;
		logic [15:0]          angle_q8;
		logic [1:0]           segment;
		apl_pkg::apl_status_t status;
	} angle_result_t;

	logic [18:0]   block_sum;
	logic [6:0]    block_count;
	logic [2:0]    log2_cfg;
	logic [11:0]   bp [PTS];
	angle_result_t expected_angles [$];
	int            errors;

	function automatic angle_result_t predict_angle(input logic [11:0] avg);
		angle_result_t r;
		longint        span;
		longint        frac;
		longint        ang;
		bit            hit;
		r.average  = avg;
		r.angle_q8 = '0;
		r.segment  = '0;
		r.status   = apl_pkg::ST_NONE;
		hit        = 1'b0;
		if (avg >= bp[0]) begin
			r.status = apl_pkg::ST_CLAMP_LO;
		end else if (avg <= bp[PTS-1]) begin
			ang        = longint'(PTS - 1) * STEP * 256;
			r.angle_q8 = (ang > 65535) ? 16'hFFFF : ang[15:0];
			r.segment  = SEG_LAST;
			r.status   = apl_pkg::ST_CLAMP_HI;
		end else begin
			for (int i = 0; i < PTS - 1; i++) begin
				if (!hit && avg <= bp[i] && avg >= bp[i+1]) begin
					span = bp[i] - bp[i+1];
					frac = 0;
					if (span != 0)
						frac = (longint'(bp[i] - avg) * STEP * 256) / span;
					ang        = longint'(i) * STEP * 256 + frac;
					r.angle_q8 = (ang > 65535) ? 16'hFFFF : ang[15:0];
					r.segment  = 2'(i);
					r.status   = apl_pkg::ST_INTERP;
					hit        = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angle_result_t want;
		logic [18:0]   shifted;
		logic [11:0]   avg;
		logic [7:0]    target;
		if (!arst_n) begin
			block_sum   = '0;
			block_count = '0;
			log2_cfg    = apl_pkg::AVG_LOG2_RESET;
			bp[0]       = 12'd4095;
			bp[1]       = 12'd3071;
			bp[2]       = 12'd2047;
			bp[3]       = 12'd1023;
			bp[4]       = 12'd0;
			expected_angles.delete();
			errors      = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// Results are checked before this edge's sample is predicted.
			if (pop && !empty) begin
				if (expected_angles.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got average %0d angle %0d",
						$time, average, angle_q8);
				end else begin
					want = expected_angles.pop_front();
					if (average !== want.average) begin
						errors++;
						$display("%0t: average: expected %0d, got %0d",
							$time, want.average, average);
					end
					if (angle_q8 !== want.angle_q8) begin
						errors++;
						$display("%0t: angle_q8: expected %0d, got %0d",
							$time, want.angle_q8, angle_q8);
					end
					if (segment !== want.segment) begin
						errors++;
						$display("%0t: segment: expected %0d, got %0d",
							$time, want.segment, segment);
					end
					if (status !== want.status) begin
						errors++;
						$display("%0t: status: expected %0d, got %0d",
							$time, want.status, status);
					end
				end
			end
			if (cfg_wr_en) begin
				if (cfg_addr == apl_pkg::CFG_AVG_LOG2)
					log2_cfg = cfg_wdata[2:0];
				else if (cfg_addr >= apl_pkg::CFG_BP_FIRST &&
				         cfg_addr < apl_pkg::CFG_BP_FIRST + apl_pkg::BP_REGS)
					bp[cfg_addr - apl_pkg::CFG_BP_FIRST] = cfg_wdata;
			end
			if (push && !full) begin
				block_sum   = block_sum + sample;
				block_count = block_count + 7'd1;
				target      = 8'd1 << log2_cfg;
				if (block_count == 0 || block_count >= target) begin
					shifted = block_sum >> log2_cfg;
					avg     = (shifted > 19'd4095) ? 12'hFFF : shifted[11:0];
					expected_angles.push_back(predict_angle(avg));
					block_sum   = '0;
					block_count = '0;
				end
			end
			fail_count <= errors;
			pending    <= expected_angles.size();
		end
	end

endmodule

// ===== test/averaged_piecewise_linearizer_tb.sv =====
module averaged_piecewise_linearizer_tb;

	// A quiet stretch longer than this means the block has hung. The longest
	// legal silence is the deliberate receiver hold plus one divide.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed for the pipeline to drain before a register write and at
	// the end; comfortably above the interpolation latency.
	localparam int SETTLE_CYCLES  = 40;
	localparam int PRESSURE_HOLD  = 400;
	localparam int TARGET_ITEMS   = 550;
	localparam int PTS            = apl_pkg::POINTS_DEF;
	localparam logic [2:0] CFG_SPARE = 3'(apl_pkg::CFG_BP_FIRST + apl_pkg::BP_REGS);

	logic        clk;
	logic        arst_n;
	logic        push;
	logic [11:0] sample;
	logic        full;
	logic        empty;
	logic        pop;
	logic [11:0] average;
	logic [15:0] angle_q8;
	logic [1:0]  segment;
	logic [1:0]  status;
	logic        cfg_wr_en;
	logic [2:0]  cfg_addr;
	logic [11:0] cfg_wdata;

	int fail_count;
	int pending;
	int quiet_cycles;
	bit sender_idles;
	bit pressure_req;
	bit pressure_done;

	averaged_piecewise_linearizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.average   (average),
		.angle_q8  (angle_q8),
		.segment   (segment),
		.status    (status),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// The checker watches both channels and the register port on its own;
	// this module only produces traffic and reports the outcome.
	angle_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.sample     (sample),
		.full       (full),
		.empty      (empty),
		.pop        (pop),
		.average    (average),
		.angle_q8   (angle_q8),
		.segment    (segment),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly back-to-back or short gaps, with the occasional long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one sample and returns right after the edge that accepted it.
	// All input changes happen on the falling edge, so push is never lowered
	// and raised again within one time step.
	task automatic send_sample(input int value);
		int gap;
		gap = sender_idles ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push   <= 1'b1;
		sample <= 12'(value);
		do @(posedge clk); while (full);
	endtask

	// Stops offering samples, then waits for every outstanding result request
	// and a drain period, since the last sample may still be in flight without
	// a result of its own.
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register back to back. The upper bits of the averaging
	// field are filled with noise, and now and then one of the unmapped
	// indexes is written too, which the block must ignore.
	task automatic write_config(input int log2, input int tbl [PTS]);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= apl_pkg::CFG_AVG_LOG2;
		cfg_wdata <= {9'($urandom), 3'(log2)};
		for (int i = 0; i < apl_pkg::BP_REGS; i++) begin
			@(negedge clk);
			cfg_addr  <= apl_pkg::CFG_BP_FIRST + 3'(i);
			cfg_wdata <= 12'(tbl[i]);
		end
		if ($urandom_range(0, 1) == 1) begin
			@(negedge clk);
			cfg_addr  <= CFG_SPARE + 3'($urandom_range(0, 1));
			cfg_wdata <= 12'($urandom);
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver. It idles at random and sometimes runs a calm stretch with pop
	// held high. Once the stimulus asks for it, it refuses results for a long
	// stretch so that the divider and request queue fill and full rises.
	initial begin
		int gap_left;
		int calm_left;
		pop           = 1'b0;
		pressure_done = 1'b0;
		gap_left      = 0;
		calm_left     = 0;
		forever begin
			@(negedge clk);
			if (pressure_req && !pressure_done) begin
				pop <= 1'b0;
				for (int held = 1; held < PRESSURE_HOLD; held++)
					@(negedge clk);
				pressure_done = 1'b1;
			end else if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else begin
				pop <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					gap_left = pick_gap();
					if ($urandom_range(0, 19) == 0)
						calm_left = $urandom_range(50, 150);
				end
			end
		end
	end

	// Watchdog: counts edges at which nothing was accepted on any port.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** averaged_piecewise_linearizer: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int tbl [PTS];
		int log2;
		int n;
		int mode;
		int level;
		int spread;
		int s;
		int r;
		int tmp;
		int phase;
		int items_sent;

		arst_n       = 1'b0;
		push         = 1'b0;
		sample       = '0;
		cfg_wr_en    = 1'b0;
		cfg_addr     = '0;
		cfg_wdata    = '0;
		sender_idles = 1'b1;
		pressure_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. With one sample per block every sample yields a
		// result, so the mapping can be probed point by point: both clamps,
		// each breakpoint exactly, one step inside each segment.
		for (int i = 0; i < PTS; i++)
			tbl[i] = apl_pkg::bp_reset(i);
		wait_idle();
		write_config(0, tbl);
		send_sample(4095);
		send_sample(4094);
		send_sample(3071);
		send_sample(3070);
		send_sample(2047);
		send_sample(1024);
		send_sample(1023);
		send_sample(1);
		send_sample(0);
		send_sample(2500);

		// A table that is not monotonic: a reading between the ends falls in the
		// wide last segment, and the two ends themselves clamp.
		tbl = '{2000, 3000, 3500, 3800, 10};
		wait_idle();
		write_config(0, tbl);
		send_sample(1000);
		send_sample(2000);
		send_sample(10);

		// Repeated breakpoints give segments of zero width.
		tbl = '{4095, 2048, 2048, 2048, 0};
		wait_idle();
		write_config(0, tbl);
		send_sample(2048);
		send_sample(2047);

		// Shrinking the block size with three of four samples in the block: the
		// next sample completes it, and the mean of four full-scale readings over
		// two must saturate.
		for (int i = 0; i < PTS; i++)
			tbl[i] = apl_pkg::bp_reset(i);
		wait_idle();
		write_config(2, tbl);
		send_sample(4095);
		send_sample(4095);
		send_sample(4095);
		wait_idle();
		write_config(1, tbl);
		send_sample(4095);

		// Random part, in phases of one register setting each. Phase 0 is the
		// back-pressure phase; phase 1 fills the largest block with
		// full-scale readings to reach the widest sum.
		items_sent = 0;
		phase      = 0;
		while (items_sent < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = $urandom_range(0, 4095);
			end else if (r < 60) begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = apl_pkg::bp_reset(i);
			end else if (r < 75) begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = ($urandom_range(0, 1) == 1) ? 4095 : 0;
			end else begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = $urandom_range(0, 4095);
			end
			// Most tables are calibrated ones, so sort them descending; the
			// last branch above keeps its random, usually broken order.
			if (r < 75) begin
				for (int i = 0; i < PTS - 1; i++)
					for (int j = 0; j < PTS - 1 - i; j++)
						if (tbl[j] < tbl[j+1]) begin
							tmp      = tbl[j];
							tbl[j]   = tbl[j+1];
							tbl[j+1] = tmp;
						end
			end

			r = $urandom_range(0, 99);
			if (r < 70)
				log2 = $urandom_range(0, 3);
			else if (r < 90)
				log2 = $urandom_range(4, 6);
			else
				log2 = 7;
			n = (log2 >= 5) ? $urandom_range(40, 140) : $urandom_range(8, 60);

			// Level mode keeps the readings close to one breakpoint, so the
			// block averages land on and around the segment boundaries.
			mode   = $urandom_range(0, 1);
			level  = tbl[$urandom_range(0, PTS - 1)] + int'($urandom_range(0, 6)) - 3;
			spread = $urandom_range(0, 3);
			sender_idles = ($urandom_range(0, 3) != 0);

			if (phase == 0) begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = apl_pkg::bp_reset(i);
				log2         = 0;
				n            = 80;
				mode         = 0;
				sender_idles = 1'b0;
			end else if (phase == 1) begin
				for (int i = 0; i < PTS; i++)
					tbl[i] = apl_pkg::bp_reset(i);
				log2   = 7;
				n      = 130;
				mode   = 1;
				level  = 4095;
				spread = 0;
			end
			if (level < 0)
				level = 0;
			if (level > 4095)
				level = 4095;

			wait_idle();
			write_config(log2, tbl);
			if (phase == 0)
				pressure_req = 1'b1;

			for (int k = 0; k < n && items_sent < TARGET_ITEMS; k++) begin
				if (mode == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						case ($urandom_range(0, 3))
							0: begin
								s = 0;
							end
							1: begin
								s = 1;
							end
							2: begin
								s = 4094;
							end
							default: begin
								s = 4095;
							end
						endcase
					end else begin
						s = $urandom_range(0, 4095);
					end
				end else begin
					s = level + int'($urandom_range(0, 2 * spread)) - spread;
					if (s < 0)
						s = 0;
					if (s > 4095)
						s = 4095;
				end
				send_sample(s);
				items_sent++;
			end
			phase++;
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("** averaged_piecewise_linearizer: PASSED **");
		else
			$display("** averaged_piecewise_linearizer: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/apl_pkg.sv
design/apl_queue.sv
design/apl_front.sv
design/apl_back.sv
design/averaged_piecewise_linearizer.sv
design/apl_checker.sv
test/angle_result_checker.sv
test/averaged_piecewise_linearizer_tb.sv
